### rtl/core/rhp_pkg.sv
// Shared types and constants for the RTP header parser.
// No dependencies; used by every module in rtl/core.
`default_nettype none

package rhp_pkg;

    // Header geometry
    localparam int FIXED_BYTES          = 12;
    localparam int WORD_BYTES           = 4;
    localparam int MAX_PACKET_BYTES_DEF = 65535;

    // Output queue geometry
    localparam int OQ_DEPTH = 4;
    localparam int OQ_AW    = $clog2(OQ_DEPTH);

    // RTP version carried in the top two header bits
    localparam logic [1:0] HDR_VERSION = 2'd2;

    // Result kinds
    localparam logic KIND_CSRC    = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_SHORT_FIXED = 3'd1,
        ST_BAD_VERSION = 3'd2,
        ST_SHORT_HDR   = 3'd3,
        ST_EXT_OVERRUN = 3'd4,
        ST_PAD_OVERRUN = 3'd5
    } t_rhp_status;

    // Input beat
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last;
    } t_rhp_in;

    // Result beat
    typedef struct packed {
        logic        kind;
        logic [31:0] word;
        t_rhp_status status;
        logic        marker;
        logic [6:0]  payload_type;
        logic [15:0] sequence_res;
        logic [31:0] timestamp;
        logic [3:0]  csrc_count;
        logic [15:0] extension_profile;
        logic [15:0] extension_bytes;
        logic [15:0] payload_offset;
        logic [15:0] payload_length;
    } t_rhp_out;

    // Results produced by one parsed byte, CSRC word first
    typedef struct packed {
        logic     csrc_vld;
        logic     sum_vld;
        t_rhp_out csrc;
        t_rhp_out sum;
    } t_rhp_push;

endpackage

`default_nettype wire

### rtl/core/rtp_header_parser_core.sv
// Top level of the RTP header parser: input register, decoder, result queue.
// Depends on rhp_pkg, rhp_parse and rhp_out_fifo.
`default_nettype none

// Takes one packet byte per beat (last flags the final byte) and can accept a
// byte every cycle. A byte is held in an input register, decoded from there
// once the result queue has room for its beats, and its results land in a
// four-entry queue whose oldest entry drives the output. A byte yields up to
// two beats: a CSRC word (version 2 headers only) and, on the last byte, the
// packet summary, always after the CSRC beat. The input side stalls only
// while the result queue has fewer than two free entries, i.e. when the
// consumer holds off output beats.
module rtp_header_parser_core #(
    parameter int MAX_PACKET_BYTES = rhp_pkg::MAX_PACKET_BYTES_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire rhp_pkg::t_rhp_in  i_item,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output rhp_pkg::t_rhp_out      o_item
);

    logic              r_in_valid, n_in_valid;
    rhp_pkg::t_rhp_in  r_in;
    logic              fire, space, accept;
    rhp_pkg::t_rhp_push push;

    // Input register handshake
    always_comb begin
        fire       = r_in_valid && space;
        o_ready    = !r_in_valid || fire;
        accept     = i_valid && o_ready;
        n_in_valid = accept || (r_in_valid && !fire);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in <= i_item;
        end
    end

    rhp_parse #(
        .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
    ) u_parse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_item  (r_in),
        .o_push  (push)
    );

    rhp_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_space (space),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_item  (o_item)
    );

    // Checks
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !space) |=> (r_in_valid && $stable(r_in)))
        else $error("held byte lost while queue full");

    a_push_needs_fire: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push.csrc_vld || push.sum_vld) |-> fire)
        else $error("result beat without a decoded byte");

    a_ready_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (r_in_valid && !space))
        else $error("input stalled without cause");

endmodule

`default_nettype wire

### rtl/core/rhp_parse.sv
// Byte-at-a-time RTP header decode: header capture, CSRC words, packet summary.
// Depends on rhp_pkg.
`default_nettype none

module rhp_parse #(
    parameter int MAX_PACKET_BYTES = rhp_pkg::MAX_PACKET_BYTES_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_fire,
    input  wire rhp_pkg::t_rhp_in  i_item,
    output rhp_pkg::t_rhp_push     o_push
);

    localparam logic [15:0] MAX_CNT = 16'(MAX_PACKET_BYTES);

    logic [15:0] r_byte_count, n_byte_count;
    logic [31:0] r_word_shift, n_word_shift;
    logic [31:0] r_first_word, n_first_word;
    logic [31:0] r_time_stamp, n_time_stamp;
    logic [31:0] r_source_id,  n_source_id;
    logic [15:0] r_ext_profile, n_ext_profile;
    logic [15:0] r_ext_words,  n_ext_words;

    logic        cnt_ok, word_end, is_fixed_word, csrc_hit, ext_hit;
    logic [6:0]  hdr_cur, hdr_new;
    logic        x_cur, x_new, p_new;
    logic [7:0]  need_len;
    logic [15:0] avail, avail2, offset, plen;
    logic [17:0] ext_len;
    logic [18:0] ext_need;
    logic [7:0]  pad;
    logic        short_fixed, bad_ver, short_hdr, ext_over, pad_over;
    rhp_pkg::t_rhp_status status;

    // Per-byte capture
    always_comb begin
        cnt_ok        = r_byte_count < MAX_CNT;
        hdr_cur       = 7'(rhp_pkg::FIXED_BYTES) + {1'b0, r_first_word[27:24], 2'b00};
        x_cur         = r_first_word[28];
        word_end      = cnt_ok && (r_byte_count[1:0] == 2'b11);
        is_fixed_word = (r_byte_count == 16'd3) || (r_byte_count == 16'd7)
                     || (r_byte_count == 16'd11);

        n_word_shift = cnt_ok ? {r_word_shift[23:0], i_item.data_byte} : r_word_shift;
        n_byte_count = cnt_ok ? r_byte_count + 16'd1 : r_byte_count;

        n_first_word = (word_end && r_byte_count == 16'd3)  ? n_word_shift : r_first_word;
        n_time_stamp = (word_end && r_byte_count == 16'd7)  ? n_word_shift : r_time_stamp;
        n_source_id  = (word_end && r_byte_count == 16'd11) ? n_word_shift : r_source_id;

        csrc_hit = word_end && !is_fixed_word && (r_byte_count < {9'd0, hdr_cur})
                && (r_first_word[31:30] == rhp_pkg::HDR_VERSION);
        ext_hit  = word_end && !is_fixed_word && !(r_byte_count < {9'd0, hdr_cur})
                && x_cur && (r_byte_count == {9'd0, hdr_cur} + 16'd3);

        n_ext_profile = ext_hit ? n_word_shift[31:16] : r_ext_profile;
        n_ext_words   = ext_hit ? n_word_shift[15:0]  : r_ext_words;
    end

    // Summary arithmetic on the updated header state
    always_comb begin
        hdr_new  = 7'(rhp_pkg::FIXED_BYTES) + {1'b0, n_first_word[27:24], 2'b00};
        x_new    = n_first_word[28];
        p_new    = n_first_word[29];
        need_len = {1'b0, hdr_new} + (x_new ? 8'd4 : 8'd0) + {7'd0, p_new};

        short_fixed = n_byte_count < 16'(rhp_pkg::FIXED_BYTES);
        bad_ver     = n_first_word[31:30] != rhp_pkg::HDR_VERSION;
        short_hdr   = n_byte_count < {8'd0, need_len};

        avail    = n_byte_count - {9'd0, hdr_new};
        ext_len  = {n_ext_words, 2'b00};
        ext_need = {1'b0, ext_len} + 19'(rhp_pkg::WORD_BYTES);
        ext_over = x_new && (ext_need > {3'd0, avail});
        avail2   = x_new ? avail - ext_need[15:0] : avail;
        pad      = p_new ? i_item.data_byte : 8'd0;
        pad_over = {8'd0, pad} > avail2;
        offset   = n_byte_count - avail2;
        plen     = avail2 - {8'd0, pad};

        if (short_fixed) begin
            status = rhp_pkg::ST_SHORT_FIXED;
        end else if (bad_ver) begin
            status = rhp_pkg::ST_BAD_VERSION;
        end else if (short_hdr) begin
            status = rhp_pkg::ST_SHORT_HDR;
        end else if (ext_over) begin
            status = rhp_pkg::ST_EXT_OVERRUN;
        end else if (pad_over) begin
            status = rhp_pkg::ST_PAD_OVERRUN;
        end else begin
            status = rhp_pkg::ST_OK;
        end
    end

    // Result beats
    always_comb begin
        o_push          = '0;
        o_push.csrc_vld = i_fire && csrc_hit;
        o_push.sum_vld  = i_fire && i_item.last;

        o_push.csrc.kind = rhp_pkg::KIND_CSRC;
        o_push.csrc.word = n_word_shift;

        o_push.sum.kind   = rhp_pkg::KIND_SUMMARY;
        o_push.sum.status = status;
        if (!short_fixed) begin
            o_push.sum.word         = n_source_id;
            o_push.sum.marker       = n_first_word[23];
            o_push.sum.payload_type = n_first_word[22:16];
            o_push.sum.sequence_res = n_first_word[15:0];
            o_push.sum.timestamp    = n_time_stamp;
            o_push.sum.csrc_count   = n_first_word[27:24];
            if (!bad_ver && !short_hdr && x_new) begin
                o_push.sum.extension_profile = n_ext_profile;
                o_push.sum.extension_bytes   = (|ext_len[17:16]) ? 16'hFFFF : ext_len[15:0];
            end
            if (status == rhp_pkg::ST_OK) begin
                o_push.sum.payload_offset = offset;
                o_push.sum.payload_length = plen;
            end
        end
    end

    // State registers; cleared after the last byte of each packet
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_fire && i_item.last)) begin
            r_byte_count  <= '0;
            r_word_shift  <= '0;
            r_first_word  <= '0;
            r_time_stamp  <= '0;
            r_source_id   <= '0;
            r_ext_profile <= '0;
            r_ext_words   <= '0;
        end else if (i_fire) begin
            r_byte_count  <= n_byte_count;
            r_word_shift  <= n_word_shift;
            r_first_word  <= n_first_word;
            r_time_stamp  <= n_time_stamp;
            r_source_id   <= n_source_id;
            r_ext_profile <= n_ext_profile;
            r_ext_words   <= n_ext_words;
        end
    end

    // Checks
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_byte_count <= MAX_CNT)
        else $error("byte count past packet limit");

    a_csrc_ver: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push.csrc_vld |-> (r_first_word[31:30] == rhp_pkg::HDR_VERSION
                             && r_byte_count > 16'd11))
        else $error("CSRC beat outside a version 2 header");

    a_sum_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push.sum_vld |=> (r_byte_count == 16'd0 && r_first_word == 32'd0))
        else $error("packet state not cleared after summary");

endmodule

`default_nettype wire

### rtl/core/rhp_out_fifo.sv
// Small result queue taking up to two beats per cycle, one beat out per cycle.
// Depends on rhp_pkg.
`default_nettype none

module rhp_out_fifo (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire rhp_pkg::t_rhp_push i_push,
    output logic                    o_space,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output rhp_pkg::t_rhp_out       o_item
);

    localparam int AW = rhp_pkg::OQ_AW;
    localparam int CW = AW + 1;

    rhp_pkg::t_rhp_out r_mem [rhp_pkg::OQ_DEPTH];

    logic [AW-1:0] r_wr_ptr, n_wr_ptr, r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count, n_count;
    logic [AW-1:0] sum_ptr;
    logic [1:0]    push_n;
    logic          pop;

    // Pointer and occupancy
    always_comb begin
        o_valid  = r_count != '0;
        push_n   = {1'b0, i_push.csrc_vld} + {1'b0, i_push.sum_vld};
        pop      = o_valid && i_ready;
        sum_ptr  = r_wr_ptr + AW'(i_push.csrc_vld);
        n_wr_ptr = r_wr_ptr + AW'(push_n);
        n_rd_ptr = r_rd_ptr + AW'(pop);
        n_count  = r_count + CW'(push_n) - CW'(pop);
        o_space  = r_count <= CW'(rhp_pkg::OQ_DEPTH - 2);
        o_item   = r_mem[r_rd_ptr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Storage; CSRC beat goes ahead of the summary
    always_ff @(posedge i_clk) begin
        if (i_push.csrc_vld) begin
            r_mem[r_wr_ptr] <= i_push.csrc;
        end
        if (i_push.sum_vld) begin
            r_mem[sum_ptr] <= i_push.sum;
        end
    end

    // Checks
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_count} + {2'b0, push_n} - {{CW{1'b0}}, pop})
            <= (CW + 1)'(rhp_pkg::OQ_DEPTH))
        else $error("result queue overflow");

    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == CW'(1) && pop && push_n == 2'd0) |=> !o_valid)
        else $error("queue not empty after draining last beat");

    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wr_ptr - r_rd_ptr) == r_count[AW-1:0])
        else $error("queue pointers disagree with count");

endmodule

`default_nettype wire

### verif/tb_rtp_header_parser_core.sv
`timescale 1ns / 1ps
// Self-checking bench for rtp_header_parser_core: byte-stream packets in, CSRC and
// summary beats out, checked against a bit-true header decoder kept in this file.
// Depends on rhp_pkg and the RTL under rtl/core.

module tb_rtp_header_parser_core;
    import rhp_pkg::*;

    localparam int CLK_PERIOD = 10;
    localparam int MAX_BYTES  = MAX_PACKET_BYTES_DEF;
    localparam int LONG_HOLD  = 400;
    localparam int IDLE_UNTIL = 1150;   // byte count where idling stops
    localparam int RAND_BYTES = 1450;   // byte count where random packets stop
    localparam int TAIL_WAIT  = 8;
    localparam int N_DIR      = 17;

    // Directed packet: up to 24 bytes, byte 0 in the top lane. Rows with typed set carry
    // the expected summary status, offset and length; its header fields are all zero.
    typedef struct packed {
        logic [7:0]       len;
        logic [0:23][7:0] pkt;
        logic             typed;
        t_rhp_status      t_status;
        logic [15:0]      t_off;
        logic [15:0]      t_len;
    } t_dir_row;

    // Per-packet note: a typed summary replaces the decoder's one
    typedef struct packed {
        logic     typed;
        t_rhp_out sum;
    } t_sum_note;

    t_dir_row dir_tab [N_DIR] = '{
        '{8'd1,  192'hFF000000_00000000_00000000_00000000_00000000_00000000,
          1'b1, ST_SHORT_FIXED, 16'd0, 16'd0},
        '{8'd11, 192'h80FFFFFF_FFFFFFFF_FFFFFF00_00000000_00000000_00000000,
          1'b1, ST_SHORT_FIXED, 16'd0, 16'd0},
        '{8'd12, 192'h00000000_00000000_00000000_00000000_00000000_00000000,
          1'b1, ST_BAD_VERSION, 16'd0, 16'd0},
        '{8'd12, 192'h80000000_00000000_00000000_00000000_00000000_00000000,
          1'b1, ST_OK, 16'd12, 16'd0},
        '{8'd24, 192'hFFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFF,
          1'b0, ST_OK, 16'd0, 16'd0},
        '{8'd20, 192'h82FFFFFF_FFFFFFFF_FFFFFFFF_DEADBEEF_00000000_00000000,
          1'b0, ST_OK, 16'd0, 16'd0},
        '{8'd24, 192'h8F000001_12345678_9ABCDEF0_11111111_22222222_33333333,
          1'b0, ST_OK, 16'd0, 16'd0},
        '{8'd21, 192'h907F0002_00000000_00000000_ABCD0001_11223344_55000000,
          1'b0, ST_OK, 16'd0, 16'd0},
        '{8'd16, 192'h90000000_00000000_00000000_00000001_00000000_00000000,
          1'b0, ST_OK, 16'd0, 16'd0},
        '{8'd18, 192'h90000000_00000000_00000000_BEDEFFFF_AAAA0000_00000000,
          1'b0, ST_OK, 16'd0, 16'd0},
        '{8'd16, 192'hA0000000_00000000_00000000_00000004_00000000_00000000,
          1'b1, ST_OK, 16'd12, 16'd0},
        '{8'd16, 192'hA0000000_00000000_00000000_00000005_00000000_00000000,
          1'b1, ST_PAD_OVERRUN, 16'd0, 16'd0},
        '{8'd12, 192'hA0000000_00000000_00000000_00000000_00000000_00000000,
          1'b1, ST_SHORT_HDR, 16'd0, 16'd0},
        '{8'd12, 192'hB0000000_00000000_00000000_00000000_00000000_00000000,
          1'b1, ST_SHORT_HDR, 16'd0, 16'd0},
        '{8'd16, 192'h4F000000_00000000_00000000_CAFEF00D_00000000_00000000,
          1'b0, ST_OK, 16'd0, 16'd0},
        '{8'd23, 192'hB1601234_0000A000_5555AAAA_C0C0C0C0_01000000_77880200,
          1'b0, ST_OK, 16'd0, 16'd0},
        '{8'd13, 192'h80000000_00000000_00000000_FF000000_00000000_00000000,
          1'b1, ST_OK, 16'd12, 16'd1}
    };

    logic     i_clk = 1'b0;
    logic     i_rst_n;
    logic     i_valid;
    logic     o_ready;
    t_rhp_in  i_item;
    logic     o_valid;
    logic     i_ready = 1'b0;
    t_rhp_out o_item;

    // Decoder state, mirrors the block's header registers
    logic [15:0] byte_cnt  = '0;
    logic [31:0] shift_w   = '0;
    logic [31:0] hdr_word0 = '0;
    logic [31:0] ts_w      = '0;
    logic [31:0] ssrc_w    = '0;
    logic [15:0] ext_prof  = '0;
    logic [15:0] ext_words = '0;

    t_rhp_out    header_beats_q [$];
    t_sum_note   sum_note_q [$];
    t_sum_note   cur_note;
    logic [7:0]  pkt_buf [$];

    logic        src_idle_en   = 1'b1;
    logic        sink_stall_en = 1'b1;
    logic        hold_req      = 1'b0;

    int          fail_cnt      = 0;
    int          beats_checked = 0;
    int          csrc_checked  = 0;
    int          packets_sent  = 0;
    int          bytes_sent    = 0;
    int          status_seen [6] = '{default: 0};

    rtp_header_parser_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_item  (i_item),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_item  (o_item)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Header decoder: one packet byte in, CSRC and summary beats queued
    function automatic void rtp_decode_byte(input logic [7:0] b, input logic is_last);
        int       idx, cc, hdr_len, n_bytes, ext_len, avail, pad;
        logic     xbit, pbit;
        t_rhp_out r;
        cc      = int'(hdr_word0[27:24]);
        hdr_len = FIXED_BYTES + cc * WORD_BYTES;
        xbit    = hdr_word0[28];

        // capture stops once the count saturates
        if (int'(byte_cnt) < MAX_BYTES) begin
            idx     = int'(byte_cnt);
            shift_w = {shift_w[23:0], b};
            if (idx % WORD_BYTES == WORD_BYTES - 1) begin
                if (idx == 3) begin
                    hdr_word0 = shift_w;
                    cc        = int'(hdr_word0[27:24]);
                    hdr_len   = FIXED_BYTES + cc * WORD_BYTES;
                    xbit      = hdr_word0[28];
                end else if (idx == 7) begin
                    ts_w = shift_w;
                end else if (idx == 11) begin
                    ssrc_w = shift_w;
                end else if (idx < hdr_len) begin
                    if (hdr_word0[31:30] == HDR_VERSION) begin
                        r      = '0;
                        r.kind = KIND_CSRC;
                        r.word = shift_w;
                        header_beats_q.push_back(r);
                    end
                end else if (xbit && idx == hdr_len + 3) begin
                    ext_prof  = shift_w[31:16];
                    ext_words = shift_w[15:0];
                end
            end
            byte_cnt = 16'(idx + 1);
        end

        // packet summary on the final byte
        if (is_last) begin
            n_bytes = int'(byte_cnt);
            pbit    = hdr_word0[29];
            ext_len = int'(ext_words) * WORD_BYTES;
            pad     = pbit ? int'(b) : 0;
            r       = '0;
            r.kind  = KIND_SUMMARY;
            if (n_bytes < FIXED_BYTES) begin
                r.status = ST_SHORT_FIXED;
            end else begin
                r.word         = ssrc_w;
                r.marker       = hdr_word0[23];
                r.payload_type = hdr_word0[22:16];
                r.sequence_res = hdr_word0[15:0];
                r.timestamp    = ts_w;
                r.csrc_count   = hdr_word0[27:24];
                if (hdr_word0[31:30] != HDR_VERSION) begin
                    r.status = ST_BAD_VERSION;
                end else if (n_bytes < hdr_len + (xbit ? WORD_BYTES : 0) + int'(pbit)) begin
                    r.status = ST_SHORT_HDR;
                end else begin
                    avail = n_bytes - hdr_len;
                    if (xbit) begin
                        r.extension_profile = ext_prof;
                        r.extension_bytes   = (ext_len > 65535) ? 16'hFFFF : 16'(ext_len);
                    end
                    if (xbit && ext_len + WORD_BYTES > avail) begin
                        r.status = ST_EXT_OVERRUN;
                    end else begin
                        if (xbit) avail -= ext_len + WORD_BYTES;
                        if (pad > avail) begin
                            r.status = ST_PAD_OVERRUN;
                        end else begin
                            r.payload_offset = 16'(n_bytes - avail);
                            r.payload_length = 16'(avail - pad);
                        end
                    end
                end
            end
            header_beats_q.push_back(r);
            byte_cnt  = '0;
            shift_w   = '0;
            hdr_word0 = '0;
            ts_w      = '0;
            ssrc_w    = '0;
            ext_prof  = '0;
            ext_words = '0;
        end
    endfunction

    function automatic string beat_str(input t_rhp_out r);
        return $sformatf({"kind=%0d word=%h st=%0d m=%0d pt=%0d seq=%h ts=%h cc=%0d",
                          " prof=%h extb=%0d off=%0d len=%0d"},
                         r.kind, r.word, r.status, r.marker, r.payload_type, r.sequence_res,
                         r.timestamp, r.csrc_count, r.extension_profile, r.extension_bytes,
                         r.payload_offset, r.payload_length);
    endfunction

    // Compare one output beat with the oldest expected one
    task automatic check_beat(input t_rhp_out got);
        t_rhp_out want;
        logic     bad;
        if (header_beats_q.size() == 0) begin
            fail_cnt++;
            if (fail_cnt <= 10)
                $display("[%0t] output beat with nothing expected: %s", $time, beat_str(got));
            return;
        end
        want = header_beats_q.pop_front();
        beats_checked++;
        if (want.kind == KIND_CSRC) csrc_checked++;
        else status_seen[int'(want.status)]++;
        bad = (got.kind !== want.kind) || (got.word !== want.word) ||
              (got.status !== want.status) || (got.marker !== want.marker) ||
              (got.payload_type !== want.payload_type) ||
              (got.sequence_res !== want.sequence_res) ||
              (got.timestamp !== want.timestamp) || (got.csrc_count !== want.csrc_count) ||
              (got.extension_profile !== want.extension_profile) ||
              (got.extension_bytes !== want.extension_bytes) ||
              (got.payload_offset !== want.payload_offset) ||
              (got.payload_length !== want.payload_length);
        if (bad) begin
            fail_cnt++;
            if (fail_cnt <= 10) begin
                $display("[%0t] output beat mismatch", $time);
                $display("  expected %s", beat_str(want));
                $display("  actual   %s", beat_str(got));
            end
        end
    endtask

    // Monitor: decode accepted bytes, check accepted results
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                rtp_decode_byte(i_item.data_byte, i_item.last);
                if (i_item.last) begin
                    cur_note = sum_note_q.pop_front();
                    if (cur_note.typed)
                        header_beats_q[header_beats_q.size() - 1] = cur_note.sum;
                end
            end
            if (o_valid && i_ready) check_beat(o_item);
        end
    end

    // Send pkt_buf as one packet, one beat per byte
    task automatic send_packet(input logic typed, input t_rhp_out sum);
        logic      quiet;
        t_sum_note note;
        quiet      = ($urandom_range(0, 3) == 0);
        note.typed = typed;
        note.sum   = sum;
        sum_note_q.push_back(note);
        packets_sent++;
        foreach (pkt_buf[i]) begin
            if (src_idle_en && !quiet && $urandom_range(0, 9) == 0) begin
                i_valid <= 1'b0;
                repeat ($urandom_range(1, 15)) @(negedge i_clk);
            end
            i_valid <= 1'b1;
            i_item  <= '{data_byte: pkt_buf[i], last: (i == pkt_buf.size() - 1)};
            do @(posedge i_clk); while (!o_ready);
            bytes_sent++;
            @(negedge i_clk);
        end
    endtask

    // Random packet: mostly well-formed version 2, some truncated, foreign version
    // or plain noise. force_cc >= 0 gives a well-formed packet with that CSRC count.
    function automatic void build_random_packet(input int force_cc);
        int         sel, cc, ext_w, plen, cut, r;
        logic       p, x;
        logic [1:0] ver;
        pkt_buf.delete();
        sel = (force_cc >= 0) ? 0 : $urandom_range(0, 99);
        if (sel >= 95) begin
            repeat ($urandom_range(1, 30)) pkt_buf.push_back(8'($urandom));
            return;
        end
        p   = 1'($urandom_range(0, 1));
        x   = 1'($urandom_range(0, 1));
        ver = HDR_VERSION;
        if (sel >= 85) begin
            ver = 2'($urandom_range(0, 2));
            if (ver == HDR_VERSION) ver = 2'd3;
        end
        if (force_cc >= 0) cc = force_cc;
        else cc = ($urandom_range(0, 9) < 6) ? $urandom_range(0, 2) : $urandom_range(0, 15);
        pkt_buf.push_back({ver, p, x, 4'(cc)});
        repeat (11 + WORD_BYTES * cc) pkt_buf.push_back(8'($urandom));

        // extension: short bodies fit, huge lengths overrun
        if (x) begin
            r = $urandom_range(0, 19);
            if (r < 17) ext_w = $urandom_range(0, 3);
            else if (r == 17) ext_w = 65535;
            else if (r == 18) ext_w = 16384;
            else ext_w = $urandom_range(0, 65535);
            pkt_buf.push_back(8'($urandom));
            pkt_buf.push_back(8'($urandom));
            pkt_buf.push_back(8'(ext_w >> 8));
            pkt_buf.push_back(8'(ext_w));
            repeat ((ext_w <= 3) ? ext_w * WORD_BYTES : $urandom_range(0, 8))
                pkt_buf.push_back(8'($urandom));
        end

        // payload, final byte holds the pad count when P is set
        plen = $urandom_range(p ? 1 : 0, 12);
        repeat (plen) pkt_buf.push_back(8'($urandom));
        if (p)
            pkt_buf[pkt_buf.size() - 1] = ($urandom_range(0, 9) == 0) ?
                                          8'($urandom) : 8'($urandom_range(0, plen));

        if (sel >= 70 && sel < 85) begin
            cut = $urandom_range(1, pkt_buf.size());
            while (pkt_buf.size() > cut) void'(pkt_buf.pop_back());
        end
    endfunction

    // Sink: random stall bursts, calm stretches, one long hold-off on request
    initial begin
        int calm;
        calm = 0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge i_clk);
                hold_req = 1'b0;
            end else if (sink_stall_en && calm == 0 && $urandom_range(0, 7) == 0) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 15) - 1) @(negedge i_clk);
            end else begin
                i_ready <= 1'b1;
                if (calm > 0) calm--;
                else if ($urandom_range(0, 63) == 0) calm = $urandom_range(20, 120);
            end
        end
    end

    // Source and end of run
    initial begin
        t_rhp_out exp_sum;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_item  = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed packets
        for (int row = 0; row < N_DIR; row++) begin
            pkt_buf.delete();
            for (int k = 0; k < int'(dir_tab[row].len); k++)
                pkt_buf.push_back(dir_tab[row].pkt[k]);
            exp_sum                = '0;
            exp_sum.kind           = KIND_SUMMARY;
            exp_sum.status         = dir_tab[row].t_status;
            exp_sum.payload_offset = dir_tab[row].t_off;
            exp_sum.payload_length = dir_tab[row].t_len;
            send_packet(dir_tab[row].typed, exp_sum);
        end

        // sink holds off while full CSRC lists keep coming: the queue fills up
        src_idle_en = 1'b0;
        hold_req    = 1'b1;
        repeat (3) begin
            build_random_packet(15);
            send_packet(1'b0, '0);
        end
        src_idle_en = 1'b1;

        // source pauses until every result has drained
        i_valid <= 1'b0;
        while (header_beats_q.size() != 0) @(negedge i_clk);
        @(negedge i_clk);

        // random packets with idling on both sides
        while (bytes_sent < IDLE_UNTIL) begin
            build_random_packet(-1);
            send_packet(1'b0, '0);
        end

        // full rate to the end
        src_idle_en   = 1'b0;
        sink_stall_en = 1'b0;
        while (bytes_sent < RAND_BYTES) begin
            build_random_packet(-1);
            send_packet(1'b0, '0);
        end

        // drain
        i_valid <= 1'b0;
        while (header_beats_q.size() != 0) @(negedge i_clk);
        repeat (TAIL_WAIT) @(negedge i_clk);

        $display("Sent %0d packets (%0d bytes); checked %0d result beats, %0d CSRC words",
                 packets_sent, bytes_sent, beats_checked, csrc_checked);
        $display("Summaries ok/short-fixed/bad-ver/short-hdr/ext-ovr/pad-ovr: %0d %0d %0d %0d %0d %0d",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3],
                 status_seen[4], status_seen[5]);
        if (fail_cnt == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Watchdog
    initial begin
        #(64'd20_000_000);
        $display("Some tests failed");
        $finish;
    end

endmodule

### files.f
rtl/core/rhp_pkg.sv
rtl/core/rhp_parse.sv
rtl/core/rhp_out_fifo.sv
rtl/core/rtp_header_parser_core.sv
verif/tb_rtp_header_parser_core.sv
